@@ src/mpd_pkg.sv @@
// shared types, constants and helpers for the masked patch distance unit
// no dependencies; imported by every module of the block
package mpd_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned DIST_W      = 31;
  localparam int unsigned SSD_W       = 18;   // three squared byte differences
  localparam int unsigned MAX_SSD     = 195075;
  localparam int unsigned S_TDATA_W   = 80;
  localparam int unsigned S_TUSER_W   = 2;
  localparam int unsigned M_TDATA_W   = 32;
  localparam int unsigned PATCH_W_DEF = 7;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // tuser bit positions
  localparam int unsigned TUSER_A_HOLE = 0;
  localparam int unsigned TUSER_B_HOLE = 1;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_A_HOLE = 2'd1,
    KIND_B_HOLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    BK_ACC = 2'd0,
    BK_FIN = 2'd1,
    BK_DIV = 2'd2,
    BK_OUT = 2'd3
  } back_state_e;

  // one classified pixel pair, front to back
  typedef struct packed {
    kind_e             kind;
    logic [SSD_W-1:0]  ssd;
    logic              first;
    logic              row_end;
    logic              ends;
    logic [DIST_W-1:0] cutoff;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2*PIX_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {{PIX_W{1'b0}}, d} * {{PIX_W{1'b0}}, d};
  endfunction

endpackage

@@ src/mpd_front.sv @@
// front end: accepts pixel pairs, tracks row and patch position, classifies
// each pair and computes its squared difference; depends on mpd_pkg
module mpd_front #(
  parameter int unsigned PATCH_W = mpd_pkg::PATCH_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [mpd_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  logic [mpd_pkg::S_TUSER_W-1:0]  s_tuser_i,
  input  logic                           s_tlast_i,
  input  mpd_pkg::q_stat_t               q_stat_i,
  output logic                           push_o,
  output mpd_pkg::item_t                 item_o
);
  import mpd_pkg::*;

  localparam int unsigned AREA  = PATCH_W * PATCH_W;
  localparam int unsigned POS_W = $clog2(AREA);
  localparam int unsigned COL_W = $clog2(PATCH_W);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             accept;
  logic             last_pos, last_col, ends, row_end;
  logic [PIX_W-1:0] a_blue, a_green, a_red, b_blue, b_green, b_red;
  logic             a_hole, b_hole;

  assign a_blue  = s_tdata_i[7:0];
  assign a_green = s_tdata_i[15:8];
  assign a_red   = s_tdata_i[23:16];
  assign b_blue  = s_tdata_i[31:24];
  assign b_green = s_tdata_i[39:32];
  assign b_red   = s_tdata_i[47:40];
  assign a_hole  = s_tuser_i[TUSER_A_HOLE];
  assign b_hole  = s_tuser_i[TUSER_B_HOLE];

  assign s_tready_o = ~q_stat_i.full;
  assign accept     = s_tvalid_i & ~q_stat_i.full;
  assign push_o     = accept;

  assign last_pos = (pos_q == POS_W'(AREA - 1));
  assign last_col = (col_q == COL_W'(PATCH_W - 1));
  assign ends     = s_tlast_i | last_pos;
  assign row_end  = ends | last_col;

  always_comb begin
    pos_d = pos_q;
    col_d = col_q;
    if (accept) begin
      if (ends) begin
        pos_d = '0;
        col_d = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
        col_d = last_col ? '0 : col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      col_q <= '0;
    end else begin
      pos_q <= pos_d;
      col_q <= col_d;
    end
  end

  always_comb begin
    if (b_hole) begin
      item_o.kind = KIND_B_HOLE;
    end else if (a_hole) begin
      item_o.kind = KIND_A_HOLE;
    end else begin
      item_o.kind = KIND_PIXEL;
    end
    item_o.ssd     = SSD_W'(sq_diff(a_blue, b_blue)) + SSD_W'(sq_diff(a_green, b_green))
                   + SSD_W'(sq_diff(a_red, b_red));
    item_o.first   = (pos_q == '0);
    item_o.row_end = row_end;
    item_o.ends    = ends;
    item_o.cutoff  = s_tdata_i[78:48];
  end

endmodule

@@ src/mpd_queue.sv @@
// small queue of classified items between front and back
// depends on mpd_pkg
module mpd_queue #(
  parameter int unsigned DEPTH = mpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mpd_pkg::item_t   wr_item_i,
  input  logic             pop_i,
  output mpd_pkg::item_t   rd_item_o,
  output mpd_pkg::q_stat_t stat_o
);
  import mpd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign rd_item_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/mpd_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on mpd_pkg only through the shared import convention
module mpd_div #(
  parameter int unsigned NUM_W = 29,
  parameter int unsigned DEN_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  import mpd_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ src/mpd_back.sv @@
// back end: accumulates classified items, applies the hole and cutoff rules,
// scales the sum and holds the result register; depends on mpd_pkg, mpd_div
module mpd_back #(
  parameter int unsigned PATCH_W = mpd_pkg::PATCH_W_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpd_pkg::item_t             item_i,
  input  mpd_pkg::q_stat_t           q_stat_i,
  output logic                       pop_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [mpd_pkg::DIST_W-1:0] distance_o
);
  import mpd_pkg::*;

  localparam int unsigned AREA   = PATCH_W * PATCH_W;
  localparam longint      SUM_MAX = longint'(AREA) * longint'(MAX_SSD);
  localparam int unsigned SUM_W  = $clog2(SUM_MAX + 1);
  localparam int unsigned NUM_W  = $clog2(SUM_MAX * longint'(AREA) + 1);
  localparam int unsigned HCNT_W = $clog2(AREA + 1);

  back_state_e       st_q, st_d;
  logic [SUM_W-1:0]  sum_q, sum_c;
  logic [HCNT_W-1:0] hcnt_q, hcnt_c;
  logic              dec_q, dec_c;
  logic [DIST_W-1:0] dval_q, dval_c, cut_q, cut_c;
  logic [DIST_W-1:0] res_q, m_data_q;
  logic              m_vld_q;
  logic              out_free, too_many_holes;
  logic              div_start, div_done, load_out;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [HCNT_W-1:0] div_den;

  assign out_free       = ~m_vld_q | m_tready_i;
  assign too_many_holes = (hcnt_q > HCNT_W'(PATCH_W));
  assign div_num        = NUM_W'(sum_q) * NUM_W'(AREA);
  assign div_den        = HCNT_W'(AREA) - hcnt_q;

  mpd_div #(
    .NUM_W(NUM_W),
    .DEN_W(HCNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_ACC: if (pop_o && item_i.ends) st_d = BK_FIN;
      BK_FIN: st_d = (dec_q || too_many_holes) ? BK_OUT : BK_DIV;
      BK_DIV: if (div_done) st_d = BK_OUT;
      BK_OUT: if (out_free) st_d = BK_ACC;
      default: st_d = BK_ACC;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o     = (st_q == BK_ACC) & ~q_stat_i.empty;
    div_start = (st_q == BK_FIN) & ~dec_q & ~too_many_holes;
    load_out  = (st_q == BK_OUT) & out_free;
  end

  // per-item accumulation and early decisions
  always_comb begin
    cut_c  = item_i.first ? item_i.cutoff : cut_q;
    sum_c  = sum_q;
    hcnt_c = hcnt_q;
    dec_c  = dec_q;
    dval_c = dval_q;
    if (!dec_q) begin
      unique case (item_i.kind)
        KIND_B_HOLE: begin
          dec_c  = 1'b1;
          dval_c = DIST_MAX;
        end
        KIND_A_HOLE: hcnt_c = hcnt_q + HCNT_W'(1);
        KIND_PIXEL:  sum_c  = sum_q + SUM_W'(item_i.ssd);
        default: ;
      endcase
      if (!dec_c && item_i.row_end && (DIST_W'(sum_c) >= cut_c)) begin
        dec_c  = 1'b1;
        dval_c = cut_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_ACC;
      sum_q   <= '0;
      hcnt_q  <= '0;
      dec_q   <= 1'b0;
      dval_q  <= '0;
      cut_q   <= '0;
      m_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (pop_o) begin
        sum_q  <= sum_c;
        hcnt_q <= hcnt_c;
        dec_q  <= dec_c;
        dval_q <= dval_c;
        cut_q  <= cut_c;
      end else if (load_out) begin
        sum_q  <= '0;
        hcnt_q <= '0;
        dec_q  <= 1'b0;
        dval_q <= '0;
        cut_q  <= '0;
      end
      if (load_out) begin
        m_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_FIN) begin
      res_q <= dec_q ? dval_q : DIST_MAX;
    end else if (st_q == BK_DIV && div_done) begin
      res_q <= DIST_W'(div_quo);
    end
    if (load_out) begin
      m_data_q <= res_q;
    end
  end

  assign m_tvalid_o = m_vld_q;
  assign distance_o = m_data_q;

endmodule

@@ src/masked_patch_distance_unit.sv @@
// Masked sum-of-squared-differences distance between two PATCH_W x PATCH_W
// colour patches, fed one pixel pair per transaction in raster order with
// tlast on the final pair. Pixel pairs are taken one per cycle, while the
// queue is not full, into a short queue; the back end folds one queued pair
// per cycle into the running sum while the queue holds pairs, and after the
// patch's final pair it applies the hole and cutoff rules, then, unless they
// have decided the result, runs the bit-serial divider (NUM_W bits: 29 at
// PATCH_W = 7, 31 at PATCH_W = 9) that scales the sum by area over unmarked
// area, and then loads the output register once it is free. While it
// divides, the next patch's pairs fill the queue until it is full.
// depends on mpd_pkg, mpd_front, mpd_queue, mpd_back
module masked_patch_distance_unit #(
  parameter int unsigned PATCH_W     = mpd_pkg::PATCH_W_DEF,
  parameter int unsigned QUEUE_DEPTH = mpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // a_blue, a_green, a_red, b_blue, b_green, b_red, cutoff, zero pad
  input  logic [mpd_pkg::S_TDATA_W-1:0] s_tdata_i,
  // a_in_hole, b_in_hole
  input  logic [mpd_pkg::S_TUSER_W-1:0] s_tuser_i,
  input  logic                          s_tlast_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // distance, zero pad
  output logic [mpd_pkg::M_TDATA_W-1:0] m_tdata_o
);
  import mpd_pkg::*;

  logic              push, pop;
  item_t             wr_item, rd_item;
  q_stat_t           q_stat;
  logic [DIST_W-1:0] distance;

  mpd_front #(
    .PATCH_W(PATCH_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .s_tlast_i (s_tlast_i),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .item_o    (wr_item)
  );

  mpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_item_i(wr_item),
    .pop_i    (pop),
    .rd_item_o(rd_item),
    .stat_o   (q_stat)
  );

  mpd_back #(
    .PATCH_W(PATCH_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (rd_item),
    .q_stat_i  (q_stat),
    .pop_o     (pop),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .distance_o(distance)
  );

  assign m_tdata_o = {{(M_TDATA_W - DIST_W){1'b0}}, distance};

  // back end never reads an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // front end never writes a full queue
  a_push_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue pushed while full");

  // after a patch's final pair the back end stops taking items to finish it
  a_patch_end_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && rd_item.ends) |=> !pop)
    else $error("item taken while finishing a patch");

endmodule
